>>> rtl/lrukv_pkg.sv
// Shared types and constants of the LRU key-value cache.
package lrukv_pkg;

	// Width of the capacity register and of the returned value.
	localparam int CAP_W  = 5;
	localparam int READ_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request codes.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// What the table does with the request in flight.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_PROMOTE,
		OP_INSERT
	} lrukv_op_t;

	typedef struct packed {
		lrukv_op_t op;
		logic      write_val;
		logic      evict;
	} lrukv_cmd_t;

endpackage

>>> rtl/lrukv_ifs.sv
// Request and response channel interfaces of the LRU key-value cache.
interface lrukv_req_if #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [KEY_BITS-1:0]   lookup_key;
	logic [VALUE_BITS-1:0] write_value;

	modport source (output valid, action, lookup_key, write_value, input ready);
	modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lrukv_rsp_if import lrukv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [READ_W-1:0] read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink   (input valid, hit, read_value, output ready);
endinterface

>>> rtl/lrukv_match.sv
// Parallel key compare and slot selection over the whole table.
module lrukv_match import lrukv_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32,
	localparam int R_W        = $clog2(MAX_ENTRIES),
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
	input  logic [KEY_BITS-1:0]    key,
	input  logic [KEY_BITS-1:0]    keys [MAX_ENTRIES],
	input  logic [MAX_ENTRIES-1:0] valid,
	input  logic [R_W-1:0]         ranks [MAX_ENTRIES],
	input  logic [CNT_W-1:0]       live,
	output logic [MAX_ENTRIES-1:0] hit_oh,
	output logic [MAX_ENTRIES-1:0] oldest_oh,
	output logic [MAX_ENTRIES-1:0] free_oh
);

	logic [CNT_W-1:0] live_m1;

	assign live_m1 = live - CNT_W'(1);

	// Live ranks are 0 to live-1 and distinct, so the oldest entry is the one at live-1.
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit_oh[i]    = valid[i] && (keys[i] == key);
			oldest_oh[i] = valid[i] && (ranks[i] == live_m1[R_W-1:0]);
		end
	end

	// Lowest empty slot.
	assign free_oh = ~valid & (valid + MAX_ENTRIES'(1));

endmodule

>>> rtl/lrukv_store.sv
// Entry table: keys, values, valid marks, recency ranks and the live count.
module lrukv_store import lrukv_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32,
	localparam int R_W        = $clog2(MAX_ENTRIES),
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lrukv_cmd_t             cmd,
	input  logic [MAX_ENTRIES-1:0] slot_oh,
	input  logic [MAX_ENTRIES-1:0] victim_oh,
	input  logic [KEY_BITS-1:0]    key,
	input  logic [VALUE_BITS-1:0]  value,
	output logic [KEY_BITS-1:0]    keys [MAX_ENTRIES],
	output logic [MAX_ENTRIES-1:0] valid,
	output logic [R_W-1:0]         ranks [MAX_ENTRIES],
	output logic [CNT_W-1:0]       live,
	output logic [VALUE_BITS-1:0]  rd_value
);

	logic [KEY_BITS-1:0]    keys_q   [MAX_ENTRIES];
	logic [VALUE_BITS-1:0]  values_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [R_W-1:0]         ranks_q  [MAX_ENTRIES];
	logic [CNT_W-1:0]       live_q;

	logic [MAX_ENTRIES-1:0] valid_d;
	logic [R_W-1:0]         ranks_d  [MAX_ENTRIES];
	logic [CNT_W-1:0]       live_d;
	logic [R_W-1:0]         slot_rank;
	logic [R_W-1:0]         rank_p   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_left;
	logic [CNT_W-1:0]       live_m1;

	assign live_m1 = live_q - CNT_W'(1);

	always_comb begin
		slot_rank = '0;
		rd_value  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_oh[i]) begin
				slot_rank = slot_rank | ranks_q[i];
				rd_value  = rd_value | values_q[i];
			end
		end
	end

	always_comb begin
		valid_d    = valid_q;
		live_d     = live_q;
		valid_left = valid_q & ~victim_oh;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			ranks_d[i] = ranks_q[i];
			rank_p[i]  = ranks_q[i];
		end
		case (cmd.op)
			OP_PROMOTE: begin
				// Entries more recent than the promoted one age by one; on evict the oldest is dropped.
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (slot_oh[i]) begin
						rank_p[i] = '0;
					end else if (valid_q[i] && ranks_q[i] < slot_rank) begin
						rank_p[i] = ranks_q[i] + R_W'(1);
					end
					ranks_d[i] = rank_p[i];
					if (cmd.evict && valid_q[i] && rank_p[i] == live_m1[R_W-1:0]) begin
						valid_d[i] = 1'b0;
						ranks_d[i] = '0;
					end
				end
				if (cmd.evict) begin
					live_d = live_m1;
				end
			end
			OP_INSERT: begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (slot_oh[i] || !valid_left[i]) begin
						ranks_d[i] = '0;
					end else begin
						ranks_d[i] = ranks_q[i] + R_W'(1);
					end
				end
				valid_d = valid_left | slot_oh;
				if (!cmd.evict) begin
					live_d = live_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				ranks_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			live_q  <= live_d;
			ranks_q <= ranks_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_oh[i] && cmd.op == OP_INSERT) begin
				keys_q[i] <= key;
			end
			if (slot_oh[i] && cmd.write_val) begin
				values_q[i] <= value;
			end
		end
	end

	assign keys  = keys_q;
	assign valid = valid_q;
	assign ranks = ranks_q;
	assign live  = live_q;

endmodule

>>> rtl/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
// A request is taken into the request register; there every stored key is
// compared at once, the recency ranks are updated and a get's answer is
// loaded into the response register. One request is taken in every cycle
// while no get waits, and a get's response passes through the request
// register and then the response register. The only stall comes from the
// response register: a get waits while an earlier response has not been taken;
// puts give no response and never wait in the request register. The capacity
// register, read as 1 when 0 and as MAX_ENTRIES when above it, is to be
// written by the user only while no request is in flight; the block does not enforce it.
module lru_key_value_cache import lrukv_pkg::*; #(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS    = 32,
	parameter int VALUE_BITS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CAP_W-1:0]   cfg_wr_data,
	lrukv_req_if.sink          req,
	lrukv_rsp_if.source        rsp
);

	localparam int R_W   = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]      cap_q;
	logic                  valid_s1;
	logic                  action_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  rsp_valid_q;
	logic                  hit_q;
	logic [READ_W-1:0]     read_value_q;

	logic [KEY_BITS-1:0]    keys  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid;
	logic [R_W-1:0]         ranks [MAX_ENTRIES];
	logic [CNT_W-1:0]       live;
	logic [VALUE_BITS-1:0]  rd_value;
	logic [READ_W-1:0]      rd_ext;
	logic [MAX_ENTRIES-1:0] hit_oh;
	logic [MAX_ENTRIES-1:0] oldest_oh;
	logic [MAX_ENTRIES-1:0] free_oh;
	logic [MAX_ENTRIES-1:0] slot_oh;
	logic [MAX_ENTRIES-1:0] victim_oh;
	lrukv_cmd_t             cmd;

	logic          fire_s1;
	logic          s1_free;
	logic          any_hit;
	logic [EW-1:0] cap_x;
	logic [EW-1:0] eff_cap;
	logic [EW-1:0] live_x;

	assign any_hit = |hit_oh;
	assign fire_s1 = valid_s1 && (action_s1 == ACT_PUT || !rsp_valid_q || rsp.ready);
	assign s1_free = !valid_s1 || fire_s1;
	assign req.ready = s1_free;

	assign cap_x  = EW'(cap_q);
	assign live_x = EW'(live);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (cap_x > EW'(MAX_ENTRIES)) begin
			eff_cap = EW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && s1_free) begin
			action_s1 <= req.action;
			key_s1    <= req.lookup_key;
			value_s1  <= req.write_value;
		end
	end

	lrukv_match #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS)
	) u_match (
		.key       (key_s1),
		.keys      (keys),
		.valid     (valid),
		.ranks     (ranks),
		.live      (live),
		.hit_oh    (hit_oh),
		.oldest_oh (oldest_oh),
		.free_oh   (free_oh)
	);

	always_comb begin
		cmd       = '{op: OP_NONE, write_val: 1'b0, evict: 1'b0};
		slot_oh   = hit_oh;
		victim_oh = '0;
		if (fire_s1) begin
			if (action_s1 == ACT_GET) begin
				if (any_hit) begin
					cmd.op = OP_PROMOTE;
				end
			end else if (any_hit) begin
				cmd.op        = OP_PROMOTE;
				cmd.write_val = 1'b1;
				cmd.evict     = live_x > eff_cap;
			end else begin
				// A new key reuses the oldest slot once the table is at capacity.
				cmd.op        = OP_INSERT;
				cmd.write_val = 1'b1;
				cmd.evict     = live_x >= eff_cap;
				victim_oh     = cmd.evict ? oldest_oh : '0;
				slot_oh       = cmd.evict ? oldest_oh : free_oh;
			end
		end
	end

	lrukv_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS),
		.VALUE_BITS  (VALUE_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.slot_oh   (slot_oh),
		.victim_oh (victim_oh),
		.key       (key_s1),
		.value     (value_s1),
		.keys      (keys),
		.valid     (valid),
		.ranks     (ranks),
		.live      (live),
		.rd_value  (rd_value)
	);

	generate
		if (VALUE_BITS >= READ_W) begin : g_rd_trunc
			assign rd_ext = rd_value[READ_W-1:0];
		end else begin : g_rd_ext
			assign rd_ext = {{(READ_W - VALUE_BITS){1'b0}}, rd_value};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1 && action_s1 == ACT_GET) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && action_s1 == ACT_GET) begin
			hit_q        <= any_hit;
			read_value_q <= any_hit ? rd_ext : '0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;

	// The live count always agrees with the number of valid marks.
	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == int'(live))
		else $error("live count disagrees with valid marks");

	// A key is stored at most once.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit_oh))
		else $error("key matches more than one entry");

	// An insertion always finds exactly one slot.
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INSERT |-> $onehot(slot_oh))
		else $error("insertion without a single target slot");

	// A miss response carries a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !hit_q) |-> read_value_q == '0)
		else $error("miss response with non-zero value");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the LRU key-value cache: predicted lookups against observed responses.
`timescale 1ns / 1ps

module testbench;
	import lrukv_pkg::*;

	localparam int TABLE_SLOTS     = 16;
	localparam int KEY_POOL        = 24;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 134;
	// Cycles for a trailing put to leave the pipeline once every response is in.
	localparam int SETTLE          = 4;

	typedef struct packed {
		logic              hit;
		logic [READ_W-1:0] value;
	} lookup_answer_t;

	// Tracks the cache contents and holds the answers that gets still owe.
	class cache_scoreboard;
		bit [31:0]       slot_key [TABLE_SLOTS];
		bit [31:0]       slot_value [TABLE_SLOTS];
		bit              slot_live [TABLE_SLOTS];
		bit [3:0]        slot_age [TABLE_SLOTS];
		int              live_total;
		bit [CAP_W-1:0]  capacity;
		lookup_answer_t  pending_answers [$];
		int unsigned     errors;

		function new();
			foreach (slot_live[i]) begin
				slot_live[i] = 1'b0;
				slot_age[i]  = 4'd0;
			end
			live_total = 0;
			capacity   = CAP_RESET;
			errors     = 0;
		endfunction

		function void set_capacity(bit [CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		// Every live entry more recent than slot s ages by one; s becomes the newest.
		function void make_newest(int s);
			bit [3:0] age;
			age = slot_age[s];
			foreach (slot_live[i])
				if (slot_live[i] && i != s && slot_age[i] < age)
					slot_age[i]++;
			slot_age[s] = 4'd0;
		endfunction

		function int drop_oldest();
			int pick;
			pick = -1;
			foreach (slot_live[i])
				if (slot_live[i] && (pick < 0 || slot_age[i] > slot_age[pick]))
					pick = i;
			if (pick >= 0) begin
				slot_live[pick] = 1'b0;
				slot_age[pick]  = 4'd0;
				if (live_total > 0)
					live_total--;
			end
			return pick;
		endfunction

		function void note_request(logic act, logic [31:0] key, logic [31:0] val);
			int found;
			int spot;
			int cap;
			found = -1;
			spot  = -1;
			foreach (slot_live[i])
				if (found < 0 && slot_live[i] && slot_key[i] == key)
					found = i;
			cap = (capacity == 0) ? 1 : ((capacity > TABLE_SLOTS) ? TABLE_SLOTS : int'(capacity));

			if (act == ACT_GET) begin
				if (found < 0) begin
					pending_answers.push_back('{hit: 1'b0, value: '0});
				end else begin
					make_newest(found);
					pending_answers.push_back('{hit: 1'b1, value: slot_value[found]});
				end
				return;
			end

			if (found >= 0) begin
				slot_value[found] = val;
				make_newest(found);
				if (live_total > cap)
					void'(drop_oldest());
				return;
			end

			// A new key takes the slot of the evicted entry, or else the first free one.
			if (live_total >= cap)
				spot = drop_oldest();
			if (spot < 0) begin
				foreach (slot_live[i])
					if (spot < 0 && !slot_live[i])
						spot = i;
			end
			if (spot < 0)
				return;
			foreach (slot_live[i])
				if (slot_live[i])
					slot_age[i]++;
			slot_key[spot]   = key;
			slot_value[spot] = val;
			slot_live[spot]  = 1'b1;
			slot_age[spot]   = 4'd0;
			live_total++;
		endfunction

		function void check_response(logic hit, logic [READ_W-1:0] value);
			lookup_answer_t want;
			if (pending_answers.size() == 0) begin
				$display("%0t: response with no get outstanding: hit %b value %h",
					$time, hit, value);
				errors++;
				return;
			end
			want = pending_answers.pop_front();
			if (hit !== want.hit) begin
				$display("%0t: hit mismatch: expected %b, actual %b", $time, want.hit, hit);
				errors++;
			end
			if (value !== want.value) begin
				$display("%0t: read_value mismatch: expected %h, actual %h",
					$time, want.value, value);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [CAP_W-1:0]  cfg_wr_data;

	lrukv_req_if req_ch ();
	lrukv_rsp_if rsp_ch ();

	cache_scoreboard board = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic [31:0] key_pool [KEY_POOL];
	logic [CAP_W-1:0] phase_caps [PHASES] = '{
		5'd31, 5'd3, 5'd0, 5'd16, 5'd2, 5'd8, 5'd1, 5'd16, 5'd4, 5'd31, 5'd12, 5'd7
	};

	lru_key_value_cache uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Responses are checked at the edge of their transfer; ready is then redrawn.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			board.check_response(rsp_ch.hit, rsp_ch.read_value);
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(input logic act, input logic [31:0] key,
			input logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.lookup_key  <= key;
		req_ch.write_value <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		board.note_request(act, key, val);
	endtask

	task automatic drain_pipeline();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure_capacity(input logic [CAP_W-1:0] cap);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_capacity(cap);
	endtask

	initial begin
		logic        act;
		logic [31:0] key;

		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_GET;
		req_ch.lookup_key  = '0;
		req_ch.write_value = '0;
		rsp_ch.ready       = 1'b0;
		send_idle_pct      = 13;
		recv_idle_pct      = 51;
		key_pool[0]        = 32'h0000_0000;
		key_pool[1]        = 32'hFFFF_FFFF;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, extreme keys and values, overwrite and a plain miss.
		send_request(ACT_GET, 32'h0000_0000, 32'h0);
		send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(ACT_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
		send_request(ACT_GET, 32'h0000_0000, 32'h0);
		send_request(ACT_GET, 32'h1234_5678, 32'h0);
		send_request(ACT_PUT, 32'h1234_5678, 32'h5A5A_5A5A);
		send_request(ACT_PUT, 32'h0000_0001, 32'h0000_0001);
		drain_pipeline();

		// Capacity lowered below the number of live entries.
		configure_capacity(5'd2);
		send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0002);
		send_request(ACT_GET, 32'h0000_0000, 32'h0);
		send_request(ACT_PUT, 32'h0000_0077, 32'h0000_0003);
		send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
		drain_pipeline();

		// A full table of one entry evicts on every new key.
		configure_capacity(5'd1);
		send_request(ACT_PUT, 32'h0000_AAAA, 32'h0000_0004);
		send_request(ACT_PUT, 32'h0000_BBBB, 32'h0000_0005);
		send_request(ACT_GET, 32'h0000_AAAA, 32'h0);
		send_request(ACT_GET, 32'h0000_BBBB, 32'h0);
		drain_pipeline();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 13;
				recv_idle_pct = 51;
			end else if (p < 8) begin
				send_idle_pct = 51;
				recv_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 2; k < KEY_POOL; k++)
				key_pool[k] = $urandom;
			configure_capacity(phase_caps[p]);
			// A small key pool keeps hits, overwrites and evictions frequent.
			repeat (ITEMS_PER_PHASE) begin
				act = 1'($urandom_range(1));
				key = ($urandom_range(7) == 0) ? $urandom
					: key_pool[$urandom_range(KEY_POOL - 1)];
				send_request(act, key, $urandom);
			end
			drain_pipeline();
		end

		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
